>>> rtl/typed_value_cast_unit_macros.svh
// Assertion macros used by the checker file (tvcu_checker.sv).
`ifndef TYPED_VALUE_CAST_UNIT_MACROS_SVH
`define TYPED_VALUE_CAST_UNIT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define TVCU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define TVCU_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/tvcu_pkg.sv
`timescale 1ns / 1ps
package tvcu_pkg;

  // Type codes
  typedef enum logic [4:0] {
    KIND_NULL = 5'd0,
    KIND_U8   = 5'd1,
    KIND_S8   = 5'd2,
    KIND_U16  = 5'd3,
    KIND_S16  = 5'd4,
    KIND_U32  = 5'd5,
    KIND_S32  = 5'd6,
    KIND_U64  = 5'd7,
    KIND_S64  = 5'd8,
    KIND_F32  = 5'd9,
    KIND_F64  = 5'd10,
    KIND_BOOL = 5'd11,
    KIND_CHAR = 5'd12,
    KIND_VAR  = 5'd13,
    KIND_OBJ  = 5'd14,
    KIND_ARR  = 5'd15,
    KIND_FUNC = 5'd16
  } tvcu_kind_t;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_OBJ   = 3'd1,
    ERR_ARR   = 3'd2,
    ERR_INT   = 3'd3,
    ERR_FLOAT = 3'd4
  } tvcu_err_t;

  // Result of one conversion path
  typedef struct packed {
    logic        ok;
    logic [63:0] payload;
  } tvcu_cast_t;

  // Leading zero count of a nonzero 64-bit word
  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 6'(63 - i);
    end
    return n;
  endfunction

  // Sign and magnitude integer to binary64, round to nearest even
  function automatic logic [63:0] int_to_f64(input logic sgn, input logic [63:0] mag);
    logic [5:0]  n;
    logic [63:0] norm;
    logic [10:0] ex;
    logic        rnd;
    logic [62:0] body;
    n    = lzc64(mag);
    norm = mag << n;
    ex   = 11'd1086 - {5'd0, n};
    rnd  = norm[10] & ((|norm[9:0]) | norm[11]);
    body = {ex, norm[62:11]} + {62'd0, rnd};
    if (mag == 64'd0) return 64'd0;
    return {sgn, body};
  endfunction

  // Binary32 to binary64, exact; NaN becomes quiet
  function automatic logic [63:0] f32_to_f64(input logic [31:0] w);
    logic        s;
    logic [7:0]  e;
    logic [22:0] f;
    logic [4:0]  p;
    logic [23:0] sh;
    logic [10:0] ex;
    s = w[31];
    e = w[30:23];
    f = w[22:0];
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (f[i]) p = 5'(i);
    end
    sh = {1'b0, f} << (5'd23 - p);
    ex = 11'd874 + {6'd0, p};
    if (e == 8'hFF) begin
      if (f != 23'd0) return {s, 11'h7FF, 1'b1, f[21:0], 29'd0};
      return {s, 11'h7FF, 52'd0};
    end
    if (e == 8'd0) begin
      if (f == 23'd0) return {s, 63'd0};
      return {s, ex, sh[22:0], 29'd0};
    end
    return {s, 11'({3'd0, e} + 11'd896), f, 29'd0};
  endfunction

  // Binary64 to signed 64-bit, truncating, saturating; NaN gives zero
  function automatic logic [63:0] f64_to_s64(input logic [63:0] d);
    logic        s;
    logic [10:0] e;
    logic [10:0] sh;
    logic [63:0] sig;
    logic [63:0] val;
    s   = d[63];
    e   = d[62:52];
    sh  = e - 11'd1023;
    sig = {11'd0, 1'b1, d[51:0]};
    if (sh[5:0] >= 6'd52) val = sig << (sh[5:0] - 6'd52);
    else                  val = sig >> (6'd52 - sh[5:0]);
    if (e == 11'h7FF && d[51:0] != 52'd0) return 64'd0;
    if (e < 11'd1023) return 64'd0;
    if (e >= 11'd1086) return s ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s ? (64'd0 - val) : val;
  endfunction

  // Binary64 to binary32, round to nearest even, zero-extended to 64 bits
  function automatic logic [63:0] f64_to_f32(input logic [63:0] d);
    logic         s;
    logic [10:0]  e;
    logic [51:0]  f;
    logic         rnd;
    logic [30:0]  body;
    logic [10:0]  ef;
    logic [10:0]  shw;
    logic [5:0]   sh;
    logic [116:0] wide;
    logic         rsub;
    logic [30:0]  sbody;
    s    = d[63];
    e    = d[62:52];
    f    = d[51:0];
    ef   = e - 11'd896;
    rnd  = f[28] & ((|f[27:0]) | f[29]);
    body = {ef[7:0], f[51:29]} + {30'd0, rnd};
    shw  = 11'd926 - e;
    sh   = (shw > 11'd63) ? 6'd63 : shw[5:0];
    wide = {1'b1, f, 64'd0} >> sh;
    rsub = wide[63] & ((|wide[62:0]) | wide[64]);
    sbody = {8'd0, wide[86:64]} + {30'd0, rsub};
    if (e == 11'h7FF) begin
      if (f != 52'd0) return {32'd0, s, 8'hFF, 1'b1, f[50:29]};
      return {32'd0, s, 8'hFF, 23'd0};
    end
    if (e == 11'd0) return {32'd0, s, 31'd0};
    if (e >= 11'd1151) return {32'd0, s, 8'hFF, 23'd0};
    if (e >= 11'd897) return {32'd0, s, body};
    return {32'd0, s, sbody};
  endfunction

endpackage

>>> rtl/typed_value_cast_unit.sv
`timescale 1ns / 1ps
// Typed value cast unit: converts one tagged scalar to a destination type.
// Input channel: in_valid/in_ready carry a source type code, 64-bit raw
// payload and a destination type code per transaction.
// Result channel: out_valid/out_ready carry the result type code, payload,
// error code and var flag, one result per input transaction.
// Datapath: the input register, then the conversion logic into the result
// register that drives out_valid.
// Throughput: one transaction per cycle while out_ready is high; the longest
// path is the integer-to-binary64 normalize followed by the binary64-to-binary32 round.
// Reset (rst_n low, synchronous) empties both registers; out_valid drops.
// When the receiver stalls, the result register holds its transaction and
// the input register still fills, so one more transaction is taken before
// in_ready falls.
module typed_value_cast_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_src_kind,
  input  logic [63:0] in_src_payload,
  input  logic [4:0]  in_dst_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_res_kind,
  output logic [63:0] out_res_payload,
  output logic [2:0]  out_err_code,
  output logic        out_var_marked
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [4:0]  src_kind_r;
  logic [63:0] src_payload_r;
  logic [4:0]  dst_kind_r;
  logic        s2_ready;

  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  res_kind_r, res_kind_nxt;
  logic [63:0] res_payload_r, res_payload_nxt;
  logic [2:0]  err_code_r, err_code_nxt;
  logic        var_marked_r, var_marked_nxt;

  tvcu_pkg::tvcu_cast_t int_cast;
  tvcu_pkg::tvcu_cast_t real_cast;

  assign s2_ready = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  // Input register: advance when the result stage can take the held one
  assign s1_valid_nxt = in_valid ? 1'b1 : (s1_valid_r && !s2_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      src_kind_r    <= in_src_kind;
      src_payload_r <= in_src_payload;
      dst_kind_r    <= in_dst_kind;
    end
  end

  tvcu_int_cast u_int_cast (
    .src_kind    (src_kind_r),
    .src_payload (src_payload_r),
    .dst_kind    (dst_kind_r),
    .cast        (int_cast)
  );

  tvcu_real_cast u_real_cast (
    .src_kind    (src_kind_r),
    .src_payload (src_payload_r),
    .dst_kind    (dst_kind_r),
    .cast        (real_cast)
  );

  // Dispatch on the destination type
  always_comb begin
    res_kind_nxt    = src_kind_r;
    res_payload_nxt = src_payload_r;
    err_code_nxt    = tvcu_pkg::ERR_NONE;
    var_marked_nxt  = 1'b0;
    if (src_kind_r == dst_kind_r) begin
      res_kind_nxt = src_kind_r;
    end else begin
      case (dst_kind_r)
        tvcu_pkg::KIND_VAR: var_marked_nxt = 1'b1;
        tvcu_pkg::KIND_OBJ,
        tvcu_pkg::KIND_FUNC: err_code_nxt = tvcu_pkg::ERR_OBJ;
        tvcu_pkg::KIND_ARR: err_code_nxt = tvcu_pkg::ERR_ARR;
        tvcu_pkg::KIND_U8, tvcu_pkg::KIND_S8, tvcu_pkg::KIND_U16,
        tvcu_pkg::KIND_S16, tvcu_pkg::KIND_U32, tvcu_pkg::KIND_S32,
        tvcu_pkg::KIND_U64, tvcu_pkg::KIND_S64, tvcu_pkg::KIND_CHAR: begin
          if (int_cast.ok) begin
            res_kind_nxt    = dst_kind_r;
            res_payload_nxt = int_cast.payload;
          end else begin
            err_code_nxt = tvcu_pkg::ERR_INT;
          end
        end
        tvcu_pkg::KIND_F32, tvcu_pkg::KIND_F64, tvcu_pkg::KIND_BOOL: begin
          if (real_cast.ok) begin
            res_kind_nxt    = dst_kind_r;
            res_payload_nxt = real_cast.payload;
          end else begin
            err_code_nxt = tvcu_pkg::ERR_FLOAT;
          end
        end
        default: begin
          res_kind_nxt    = tvcu_pkg::KIND_NULL;
          res_payload_nxt = 64'd0;
        end
      endcase
    end
  end

  // Result register: hold while stalled
  assign out_valid_nxt = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      res_kind_r    <= res_kind_nxt;
      res_payload_r <= res_payload_nxt;
      err_code_r    <= err_code_nxt;
      var_marked_r  <= var_marked_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_kind    = res_kind_r;
  assign out_res_payload = res_payload_r;
  assign out_err_code    = err_code_r;
  assign out_var_marked  = var_marked_r;

endmodule

>>> rtl/tvcu_int_cast.sv
`timescale 1ns / 1ps
module tvcu_int_cast (
  input  logic [4:0]          src_kind,
  input  logic [63:0]         src_payload,
  input  logic [4:0]          dst_kind,
  output tvcu_pkg::tvcu_cast_t cast
);

  logic        rd_ok;
  logic [63:0] iv;
  logic [63:0] src_f64;

  // Pick the binary64 view of a float source
  assign src_f64 = (src_kind == tvcu_pkg::KIND_F32) ?
                   tvcu_pkg::f32_to_f64(src_payload[31:0]) : src_payload;

  // Read the source as a signed 64-bit value
  always_comb begin
    rd_ok = 1'b1;
    iv    = 64'd0;
    case (src_kind)
      tvcu_pkg::KIND_NULL: iv = 64'd0;
      tvcu_pkg::KIND_U8:   iv = {56'd0, src_payload[7:0]};
      tvcu_pkg::KIND_S8,
      tvcu_pkg::KIND_CHAR: iv = {{56{src_payload[7]}}, src_payload[7:0]};
      tvcu_pkg::KIND_U16:  iv = {48'd0, src_payload[15:0]};
      tvcu_pkg::KIND_S16:  iv = {{48{src_payload[15]}}, src_payload[15:0]};
      tvcu_pkg::KIND_U32:  iv = {32'd0, src_payload[31:0]};
      tvcu_pkg::KIND_S32:  iv = {{32{src_payload[31]}}, src_payload[31:0]};
      tvcu_pkg::KIND_U64,
      tvcu_pkg::KIND_S64:  iv = src_payload;
      tvcu_pkg::KIND_F32,
      tvcu_pkg::KIND_F64:  iv = tvcu_pkg::f64_to_s64(src_f64);
      tvcu_pkg::KIND_BOOL: iv = {63'd0, (src_payload != 64'd0)};
      default:             rd_ok = 1'b0;
    endcase
  end

  // Truncate to the destination width
  always_comb begin
    cast.ok = rd_ok;
    case (dst_kind)
      tvcu_pkg::KIND_U8:   cast.payload = {56'd0, iv[7:0]};
      tvcu_pkg::KIND_S8,
      tvcu_pkg::KIND_CHAR: cast.payload = {{56{iv[7]}}, iv[7:0]};
      tvcu_pkg::KIND_U16:  cast.payload = {48'd0, iv[15:0]};
      tvcu_pkg::KIND_S16:  cast.payload = {{48{iv[15]}}, iv[15:0]};
      tvcu_pkg::KIND_U32:  cast.payload = {32'd0, iv[31:0]};
      tvcu_pkg::KIND_S32:  cast.payload = {{32{iv[31]}}, iv[31:0]};
      default:             cast.payload = iv;
    endcase
  end

endmodule

>>> rtl/tvcu_real_cast.sv
`timescale 1ns / 1ps
module tvcu_real_cast (
  input  logic [4:0]          src_kind,
  input  logic [63:0]         src_payload,
  input  logic [4:0]          dst_kind,
  output tvcu_pkg::tvcu_cast_t cast
);

  logic        rd_ok;
  logic        is_int;
  logic        sgn;
  logic [63:0] sv;
  logic [63:0] mag;
  logic [63:0] d;

  // Read the source as sign, magnitude or float bits
  always_comb begin
    rd_ok  = 1'b1;
    is_int = 1'b1;
    sv     = 64'd0;
    sgn    = 1'b0;
    d      = 64'd0;
    case (src_kind)
      tvcu_pkg::KIND_NULL: sv = 64'd0;
      tvcu_pkg::KIND_U8:   sv = {56'd0, src_payload[7:0]};
      tvcu_pkg::KIND_S8,
      tvcu_pkg::KIND_CHAR: begin
        sv  = {{56{src_payload[7]}}, src_payload[7:0]};
        sgn = sv[63];
      end
      tvcu_pkg::KIND_U16:  sv = {48'd0, src_payload[15:0]};
      tvcu_pkg::KIND_S16: begin
        sv  = {{48{src_payload[15]}}, src_payload[15:0]};
        sgn = sv[63];
      end
      tvcu_pkg::KIND_U32:  sv = {32'd0, src_payload[31:0]};
      tvcu_pkg::KIND_S32: begin
        sv  = {{32{src_payload[31]}}, src_payload[31:0]};
        sgn = sv[63];
      end
      tvcu_pkg::KIND_U64:  sv = src_payload;
      tvcu_pkg::KIND_S64: begin
        sv  = src_payload;
        sgn = sv[63];
      end
      tvcu_pkg::KIND_BOOL: sv = {63'd0, (src_payload != 64'd0)};
      tvcu_pkg::KIND_F32: begin
        is_int = 1'b0;
        d      = tvcu_pkg::f32_to_f64(src_payload[31:0]);
      end
      tvcu_pkg::KIND_F64: begin
        is_int = 1'b0;
        d      = src_payload;
      end
      default: begin
        rd_ok  = 1'b0;
        is_int = 1'b0;
      end
    endcase
  end

  assign mag = sgn ? (64'd0 - sv) : sv;

  logic [63:0] dval;
  assign dval = is_int ? tvcu_pkg::int_to_f64(sgn, mag) : d;

  // Produce the destination encoding
  always_comb begin
    cast.ok = rd_ok;
    case (dst_kind)
      tvcu_pkg::KIND_F32:  cast.payload = tvcu_pkg::f64_to_f32(dval);
      tvcu_pkg::KIND_BOOL: cast.payload = {63'd0, (dval[62:0] != 63'd0)};
      default:             cast.payload = dval;
    endcase
  end

endmodule

>>> rtl/tvcu_checker.sv
`timescale 1ns / 1ps
`include "typed_value_cast_unit_macros.svh"
module tvcu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_res_kind,
  input logic [63:0] out_res_payload,
  input logic [2:0]  out_err_code,
  input logic        out_var_marked
);

  // Result channel is empty right after reset
  `TVCU_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_valid, "out_valid after reset")

  // Stalled result holds
  `TVCU_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_res_payload) && $stable(out_res_kind), "stalled result changed")

  // A var-marked result carries no error
  `TVCU_ASSERT(a_var_no_err, clk, rst_n, out_valid && out_var_marked |-> out_err_code == tvcu_pkg::ERR_NONE, "var result with error")

  // An input taken while the result stalls fills the input register and blocks the input side
  `TVCU_ASSERT(a_backpressure, clk, rst_n, out_valid && !out_ready && in_valid && in_ready |=> !in_ready || out_ready, "input taken past a full pipeline")

endmodule

bind typed_value_cast_unit tvcu_checker u_tvcu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_res_kind    (out_res_kind),
  .out_res_payload (out_res_payload),
  .out_err_code    (out_err_code),
  .out_var_marked  (out_var_marked)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] payload;
    logic [2:0]  err;
    logic        var_flag;
  } cast_res_t;

  typedef struct {
    logic [4:0]  src;
    logic [63:0] payload;
    logic [4:0]  dst;
    logic        typed_in;
    cast_res_t   res;
  } vector_t;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CALM_ITEMS   = 200;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [4:0]  in_src_kind;
  logic [63:0] in_src_payload;
  logic [4:0]  in_dst_kind;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_res_kind;
  logic [63:0] out_res_payload;
  logic [2:0]  out_err_code;
  logic        out_var_marked;

  cast_res_t   pending_casts[$];
  vector_t     vectors[$];
  int          mismatches;
  int          results_seen;
  int          items_sent;
  int          cycles;
  logic        calm;
  logic        hold_req;

  typed_value_cast_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_src_kind     (in_src_kind),
    .in_src_payload  (in_src_payload),
    .in_dst_kind     (in_dst_kind),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_res_kind    (out_res_kind),
    .out_res_payload (out_res_payload),
    .out_err_code    (out_err_code),
    .out_var_marked  (out_var_marked)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Integer magnitude to binary64, round to nearest even
  function automatic logic [63:0] mag_to_double(input logic sgn, input logic [63:0] mag);
    int          msb;
    int          sh;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [10:0] ex;
    if (mag == 64'd0) return 64'd0;
    msb = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) msb = i;
    ex = 11'(1023 + msb);
    if (msb <= 52) begin
      kept = mag << (52 - msb);
    end else begin
      sh   = msb - 52;
      kept = mag >> sh;
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
      if (kept[53]) begin
        kept = kept >> 1;
        ex   = ex + 11'd1;
      end
    end
    return {sgn, ex, kept[51:0]};
  endfunction

  // Widen binary32 to binary64 exactly; NaNs come out quiet
  function automatic logic [63:0] single_to_double(input logic [31:0] w);
    logic [63:0] t;
    if (w[30:23] == 8'hFF) begin
      if (w[22:0] != 23'd0) return {w[31], 11'h7FF, 1'b1, w[21:0], 29'd0};
      return {w[31], 11'h7FF, 52'd0};
    end
    if (w[30:23] == 8'd0) begin
      if (w[22:0] == 23'd0) return {w[31], 63'd0};
      // subnormal: value is frac * 2^-149
      t = mag_to_double(w[31], {41'd0, w[22:0]});
      return {t[63], t[62:52] - 11'd149, t[51:0]};
    end
    return {w[31], 11'({3'd0, w[30:23]} + 11'd896), w[22:0], 29'd0};
  endfunction

  // Binary64 to signed 64-bit, truncate toward zero, saturate, NaN to zero
  function automatic logic [63:0] double_to_long(input logic [63:0] d);
    int          sh;
    logic [63:0] sig;
    logic [63:0] val;
    if (d[62:52] == 11'h7FF && d[51:0] != 52'd0) return 64'd0;
    if (d[62:52] < 11'd1023) return 64'd0;
    if (d[62:52] >= 11'd1086) return d[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    sh  = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    val = (sh >= 52) ? (sig << (sh - 52)) : (sig >> (52 - sh));
    return d[63] ? (64'd0 - val) : val;
  endfunction

  // Narrow binary64 to binary32, round to nearest even, zero-extended
  function automatic logic [63:0] double_to_single(input logic [63:0] d);
    int          ex;
    int          sh;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] body;
    if (d[62:52] == 11'h7FF) begin
      if (d[51:0] != 52'd0) return {32'd0, d[63], 8'hFF, 1'b1, d[50:29]};
      return {32'd0, d[63], 8'hFF, 23'd0};
    end
    if (d[62:52] == 11'd0) return {32'd0, d[63], 31'd0};
    ex = int'(d[62:52]) - 1023;
    if (ex >= 128) return {32'd0, d[63], 8'hFF, 23'd0};
    sig = {11'd0, 1'b1, d[51:0]};
    sh  = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh >= 64) begin
      body = 32'd0;
    end else begin
      kept = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      body = (ex >= -126) ? {1'b0, 8'(ex + 127), kept[22:0]} : kept[31:0];
      // carry out of the fraction bumps the exponent, up to infinity
      if (rem > half || (rem == half && kept[0])) body = body + 32'd1;
    end
    return {32'd0, d[63], body[30:0]};
  endfunction

  function automatic logic [63:0] sext_from(input logic [63:0] v, input int bits);
    logic [63:0] mask;
    mask = (64'd1 << bits) - 64'd1;
    return v[bits-1] ? (v | ~mask) : (v & mask);
  endfunction

  // Source read as signed 64-bit; ok low when the source type has no number
  function automatic logic [64:0] source_as_long(input logic [4:0] k, input logic [63:0] p);
    case (k)
      tvcu_pkg::KIND_NULL: return {1'b1, 64'd0};
      tvcu_pkg::KIND_U8:   return {1'b1, 56'd0, p[7:0]};
      tvcu_pkg::KIND_S8,
      tvcu_pkg::KIND_CHAR: return {1'b1, sext_from(p, 8)};
      tvcu_pkg::KIND_U16:  return {1'b1, 48'd0, p[15:0]};
      tvcu_pkg::KIND_S16:  return {1'b1, sext_from(p, 16)};
      tvcu_pkg::KIND_U32:  return {1'b1, 32'd0, p[31:0]};
      tvcu_pkg::KIND_S32:  return {1'b1, sext_from(p, 32)};
      tvcu_pkg::KIND_U64,
      tvcu_pkg::KIND_S64:  return {1'b1, p};
      tvcu_pkg::KIND_F32:  return {1'b1, double_to_long(single_to_double(p[31:0]))};
      tvcu_pkg::KIND_F64:  return {1'b1, double_to_long(p)};
      tvcu_pkg::KIND_BOOL: return {1'b1, 63'd0, |p};
      default:             return 65'd0;
    endcase
  endfunction

  // Source read as binary64
  function automatic logic [64:0] source_as_double(input logic [4:0] k, input logic [63:0] p);
    logic [63:0] v;
    case (k)
      tvcu_pkg::KIND_NULL: return {1'b1, 64'd0};
      tvcu_pkg::KIND_U8:   return {1'b1, mag_to_double(1'b0, {56'd0, p[7:0]})};
      tvcu_pkg::KIND_U16:  return {1'b1, mag_to_double(1'b0, {48'd0, p[15:0]})};
      tvcu_pkg::KIND_U32:  return {1'b1, mag_to_double(1'b0, {32'd0, p[31:0]})};
      tvcu_pkg::KIND_U64:  return {1'b1, mag_to_double(1'b0, p)};
      tvcu_pkg::KIND_S8, tvcu_pkg::KIND_CHAR, tvcu_pkg::KIND_S16,
      tvcu_pkg::KIND_S32, tvcu_pkg::KIND_S64: begin
        v = (k == tvcu_pkg::KIND_S16) ? sext_from(p, 16) :
            (k == tvcu_pkg::KIND_S32) ? sext_from(p, 32) :
            (k == tvcu_pkg::KIND_S64) ? p : sext_from(p, 8);
        return {1'b1, mag_to_double(v[63], v[63] ? 64'd0 - v : v)};
      end
      tvcu_pkg::KIND_F32:  return {1'b1, single_to_double(p[31:0])};
      tvcu_pkg::KIND_F64:  return {1'b1, p};
      tvcu_pkg::KIND_BOOL: return {1'b1, (|p) ? 64'h3FF0_0000_0000_0000 : 64'd0};
      default:             return 65'd0;
    endcase
  endfunction

  // Expected result of one cast
  function automatic cast_res_t predict_cast(input logic [4:0] sk, input logic [63:0] p,
                                             input logic [4:0] dk);
    cast_res_t   r;
    logic [64:0] rd;
    r = '{kind: sk, payload: p, err: tvcu_pkg::ERR_NONE, var_flag: 1'b0};
    if (sk == dk) begin
      // pass through
    end else if (dk == tvcu_pkg::KIND_VAR) begin
      r.var_flag = 1'b1;
    end else if (dk == tvcu_pkg::KIND_OBJ || dk == tvcu_pkg::KIND_FUNC) begin
      r.err = tvcu_pkg::ERR_OBJ;
    end else if (dk == tvcu_pkg::KIND_ARR) begin
      r.err = tvcu_pkg::ERR_ARR;
    end else if ((dk >= tvcu_pkg::KIND_U8 && dk <= tvcu_pkg::KIND_S64) ||
                 dk == tvcu_pkg::KIND_CHAR) begin
      rd = source_as_long(sk, p);
      if (!rd[64]) begin
        r.err = tvcu_pkg::ERR_INT;
      end else begin
        r.kind = dk;
        case (dk)
          tvcu_pkg::KIND_U8:   r.payload = {56'd0, rd[7:0]};
          tvcu_pkg::KIND_S8,
          tvcu_pkg::KIND_CHAR: r.payload = sext_from(rd[63:0], 8);
          tvcu_pkg::KIND_U16:  r.payload = {48'd0, rd[15:0]};
          tvcu_pkg::KIND_S16:  r.payload = sext_from(rd[63:0], 16);
          tvcu_pkg::KIND_U32:  r.payload = {32'd0, rd[31:0]};
          tvcu_pkg::KIND_S32:  r.payload = sext_from(rd[63:0], 32);
          default:             r.payload = rd[63:0];
        endcase
      end
    end else if (dk == tvcu_pkg::KIND_F32 || dk == tvcu_pkg::KIND_F64 ||
                 dk == tvcu_pkg::KIND_BOOL) begin
      rd = source_as_double(sk, p);
      if (!rd[64]) begin
        r.err = tvcu_pkg::ERR_FLOAT;
      end else begin
        r.kind = dk;
        if (dk == tvcu_pkg::KIND_F32)      r.payload = double_to_single(rd[63:0]);
        else if (dk == tvcu_pkg::KIND_F64) r.payload = rd[63:0];
        else                               r.payload = {63'd0, |rd[62:0]};
      end
    end else begin
      r.kind    = tvcu_pkg::KIND_NULL;
      r.payload = 64'd0;
    end
    return r;
  endfunction

  function automatic logic [63:0] pick_payload();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return w;
      1: return {w[63:8], 8'(w[1:0] == 0 ? 8'h80 : w[7:0])} & {{56{w[9]}}, 8'hFF};
      2: return {w[63:32], 32'h7F80_0000 | w[22:0] & {23{w[40]}}} ^ {32'd0, w[41], 31'd0};
      3: return {w[63], 11'h7FF, w[51:0] & {52{w[50]}}};
      4: return {w[63], 11'(1080 + w[2:0]), w[51:0]};
      5: return {w[63], 11'(890 + w[3:0]), w[51:0]};
      6: return {w[63], 11'(1149 + w[1:0]), w[51:0]};
      7: return {w[63], 11'(int'(w[5:0]) + 1003), w[51:0]};
      8: return {w[63:32], w[31], 8'(w[33:32] == 0 ? 0 : 127 + w[36:34]), w[22:0]};
      default: return w[0] ? {64{w[1]}} : {48'd0, w[15:0]};
    endcase
  endfunction

  task automatic add_vec(input logic [4:0] s, input logic [63:0] p, input logic [4:0] d,
                         input logic typed_in, input logic [4:0] rk, input logic [63:0] rp,
                         input logic [2:0] re, input logic rv);
    vector_t v;
    v.src = s; v.payload = p; v.dst = d; v.typed_in = typed_in;
    v.res = '{kind: rk, payload: rp, err: re, var_flag: rv};
    vectors.push_back(v);
  endtask

  // Offer one transaction and hold it until accepted
  task automatic send_cast(input logic [4:0] s, input logic [63:0] p, input logic [4:0] d);
    logic took;
    in_valid       <= 1'b1;
    in_src_kind    <= s;
    in_src_payload <= p;
    in_dst_kind    <= d;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  // Sender gap after an accepted transaction
  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin
    logic [4:0] s;
    logic [4:0] d;
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_src_kind    = 5'd0;
    in_src_payload = 64'd0;
    in_dst_kind    = 5'd0;

    add_vec(tvcu_pkg::KIND_U8, 64'h1FF, tvcu_pkg::KIND_U8, 1'b1,
            tvcu_pkg::KIND_U8, 64'h1FF, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_S8, 64'h80, tvcu_pkg::KIND_S64, 1'b1,
            tvcu_pkg::KIND_S64, 64'hFFFF_FFFF_FFFF_FF80, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_U64, '1, tvcu_pkg::KIND_S32, 1'b1,
            tvcu_pkg::KIND_S32, '1, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_F64, 64'h7FF8_0000_0000_0001, tvcu_pkg::KIND_S64, 1'b1,
            tvcu_pkg::KIND_S64, 64'd0, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_F64, 64'h7FF0_0000_0000_0000, tvcu_pkg::KIND_S64, 1'b1,
            tvcu_pkg::KIND_S64, 64'h7FFF_FFFF_FFFF_FFFF, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_F64, 64'hFFF0_0000_0000_0000, tvcu_pkg::KIND_U8, 1'b1,
            tvcu_pkg::KIND_U8, 64'd0, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_S32, 64'd5, tvcu_pkg::KIND_VAR, 1'b1,
            tvcu_pkg::KIND_S32, 64'd5, tvcu_pkg::ERR_NONE, 1'b1);
    add_vec(tvcu_pkg::KIND_U8, 64'd1, tvcu_pkg::KIND_OBJ, 1'b1,
            tvcu_pkg::KIND_U8, 64'd1, tvcu_pkg::ERR_OBJ, 1'b0);
    add_vec(tvcu_pkg::KIND_U8, 64'd1, tvcu_pkg::KIND_FUNC, 1'b1,
            tvcu_pkg::KIND_U8, 64'd1, tvcu_pkg::ERR_OBJ, 1'b0);
    add_vec(tvcu_pkg::KIND_S16, 64'd3, tvcu_pkg::KIND_ARR, 1'b1,
            tvcu_pkg::KIND_S16, 64'd3, tvcu_pkg::ERR_ARR, 1'b0);
    add_vec(tvcu_pkg::KIND_OBJ, 64'd7, tvcu_pkg::KIND_S32, 1'b1,
            tvcu_pkg::KIND_OBJ, 64'd7, tvcu_pkg::ERR_INT, 1'b0);
    add_vec(tvcu_pkg::KIND_OBJ, 64'd7, tvcu_pkg::KIND_F32, 1'b1,
            tvcu_pkg::KIND_OBJ, 64'd7, tvcu_pkg::ERR_FLOAT, 1'b0);
    add_vec(tvcu_pkg::KIND_U8, 64'd9, tvcu_pkg::KIND_NULL, 1'b1,
            tvcu_pkg::KIND_NULL, 64'd0, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_NULL, 64'hDEAD, tvcu_pkg::KIND_U32, 1'b1,
            tvcu_pkg::KIND_U32, 64'd0, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_BOOL, 64'h100, tvcu_pkg::KIND_U16, 1'b1,
            tvcu_pkg::KIND_U16, 64'd1, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_F64, 64'h7E37_E43C_8800_759C, tvcu_pkg::KIND_F32, 1'b1,
            tvcu_pkg::KIND_F32, 64'h7F80_0000, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_CHAR, 64'hFF, tvcu_pkg::KIND_BOOL, 1'b1,
            tvcu_pkg::KIND_BOOL, 64'd1, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_FUNC, 64'hABCD, tvcu_pkg::KIND_FUNC, 1'b1,
            tvcu_pkg::KIND_FUNC, 64'hABCD, tvcu_pkg::ERR_NONE, 1'b0);
    add_vec(tvcu_pkg::KIND_F32, 64'h8000_0000, tvcu_pkg::KIND_BOOL, 1'b1,
            tvcu_pkg::KIND_BOOL, 64'd0, tvcu_pkg::ERR_NONE, 1'b0);
    // the rest go through the predictor
    add_vec(tvcu_pkg::KIND_F32, 64'hFFFF_FFFF_FFA0_0001, tvcu_pkg::KIND_F64, 1'b0,
            5'd0, 64'd0, 3'd0, 1'b0);
    add_vec(tvcu_pkg::KIND_F64, 64'h3FF0_0000_1000_0000, tvcu_pkg::KIND_F32, 1'b0,
            5'd0, 64'd0, 3'd0, 1'b0);
    add_vec(tvcu_pkg::KIND_S64, 64'h8000_0000_0000_0000, tvcu_pkg::KIND_F64, 1'b0,
            5'd0, 64'd0, 3'd0, 1'b0);
    add_vec(tvcu_pkg::KIND_U64, '1, tvcu_pkg::KIND_F32, 1'b0,
            5'd0, 64'd0, 3'd0, 1'b0);
    add_vec(tvcu_pkg::KIND_F32, 64'h1, tvcu_pkg::KIND_F64, 1'b0,
            5'd0, 64'd0, 3'd0, 1'b0);
    add_vec(tvcu_pkg::KIND_F64, 64'h0000_0000_0000_0001, tvcu_pkg::KIND_F32, 1'b0,
            5'd0, 64'd0, 3'd0, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (vectors[i]) begin
      pending_casts.push_back(vectors[i].typed_in ? vectors[i].res :
                              predict_cast(vectors[i].src, vectors[i].payload, vectors[i].dst));
      send_cast(vectors[i].src, vectors[i].payload, vectors[i].dst);
      sender_gap();
    end

    // Random transactions
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) hold_req <= 1'b1;
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      s = 5'($urandom_range(0, 16));
      d = ($urandom_range(0, 3) == 0) ? s : 5'($urandom_range(0, 16));
      begin
        logic [63:0] p;
        p = pick_payload();
        pending_casts.push_back(predict_cast(s, p, d));
        send_cast(s, p, d);
      end
      sender_gap();
    end
    in_valid <= 1'b0;

    // Drain
    while (pending_casts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d conversions (directed table plus random kinds and edge payloads),",
             items_sent);
    $display("checked %0d results with bursty stalls and one long receiver hold-off.",
             results_seen);
    if (mismatches == 0 && pending_casts.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Receiver: bursty stalls, one long hold-off, steady at the end
  initial begin
    int   stall;
    int   hold;
    logic hold_started;
    out_ready    = 1'b0;
    stall        = 0;
    hold         = 0;
    hold_started = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_started) begin
        hold         = 64;
        hold_started = 1'b1;
      end
      if (hold > 1) begin
        hold--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest pending cast
  always @(negedge clk) begin
    cast_res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_casts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind=%0d payload=%h",
                                       out_res_kind, out_res_payload);
      end else begin
        want = pending_casts.pop_front();
        if (out_res_kind !== want.kind || out_res_payload !== want.payload ||
            out_err_code !== want.err || out_var_marked !== want.var_flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp %0d %h %0d %0d, got %0d %h %0d %0d",
                     results_seen, want.kind, want.payload, want.err, want.var_flag,
                     out_res_kind, out_res_payload, out_err_code, out_var_marked);
        end
      end
    end
  end

  // Timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/tvcu_pkg.sv
rtl/tvcu_int_cast.sv
rtl/tvcu_real_cast.sv
rtl/typed_value_cast_unit.sv
rtl/tvcu_checker.sv
bench/tb.sv
